[sv/hub_label_distance_query_core_assert.svh]
// Assertion macros shared by the hub-label distance query RTL.
`ifndef HUB_LABEL_DISTANCE_QUERY_CORE_ASSERT_SVH
`define HUB_LABEL_DISTANCE_QUERY_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define HLDQ_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hldq assertion failed");
// next-cycle implication
`define HLDQ_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hldq assertion failed");
`else
`define HLDQ_ASSERT_IMP(name, clk, rst, ante, cons)
`define HLDQ_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

[sv/hldq_pkg.sv]
// Shared types, constants and field layout of the hub-label distance query core.
`timescale 1ns / 1ps

package hldq_pkg;

   // default sizes
   localparam int unsigned VERTEX_COUNT_DEF = 1024;
   localparam int unsigned LABEL_DEPTH_DEF  = 4096;

   // field widths
   localparam int unsigned KIND_W = 3;
   localparam int unsigned IDX_W  = 12;
   localparam int unsigned HUB_W  = 10;
   localparam int unsigned DIST_W = 31;
   localparam int unsigned VTX_W  = 10;

   // request tdata layout, lowest bit first
   localparam int unsigned IDX_LSB   = 0;
   localparam int unsigned HUB_LSB   = IDX_LSB + IDX_W;
   localparam int unsigned VAL_LSB   = HUB_LSB + HUB_W;
   localparam int unsigned SRC_LSB   = VAL_LSB + DIST_W;
   localparam int unsigned DST_LSB   = SRC_LSB + VTX_W;
   localparam int unsigned REQ_BITS  = DST_LSB + VTX_W;
   localparam int unsigned REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int unsigned RSP_DATA_W = ((DIST_W + 7) / 8) * 8;

   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   // request kinds carried on tuser
   typedef enum logic [KIND_W-1:0] {
      REQ_FWD_OFS = 3'd0,
      REQ_BWD_OFS = 3'd1,
      REQ_FWD_LBL = 3'd2,
      REQ_BWD_LBL = 3'd3,
      REQ_QUERY   = 3'd4
   } req_kind_type;

   // one label entry: hub id and distance
   typedef struct packed {
      logic [HUB_W-1:0]  hub;
      logic [DIST_W-1:0] cost;
   } label_type;

   // controller to datapath
   typedef struct packed {
      logic accept;    // request beat taken this cycle
      logic q_start;   // latch query vertices
      logic off_hi;    // read offset entry v+1 instead of v
      logic lo_latch;  // capture start offsets
      logic bounds;    // load list bounds, clear min/hit
      logic step;      // one merge step
      logic load_rsp;  // move result into output register
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic active;    // both list cursors still in range
      logic rsp_free;  // output register can take a result
   } dp_stat_type;

endpackage

[sv/hub_label_distance_query_core.sv]
// Top level of the hub-label distance query core.
`timescale 1ns / 1ps
// Usage:
//   req channel: tuser carries the request kind (offset write, label write or
//   query); tdata carries index, hub, value, source and target. Writes take one
//   beat and go straight into the offset tables or label stores; a query reads
//   the two offset tables, then merge-joins the source's forward list with the
//   target's backward list, one label pair per cycle through the two store read
//   ports.
//   rsp channel: one beat per query, min distance on tdata, found on tuser.
//   A query reads the start offsets, then the end offsets, loads the list bounds,
//   runs N merge steps (at most the sum of the two list lengths) and loads its
//   result; the next beat is taken in the cycle after the load. A write beat is
//   followed by a new beat on the next cycle. One query at a time is in flight.
//   A finished result waits in an output register; while it waits, write beats
//   are taken, and a new query runs up to its result and then holds until the
//   register is freed.
//   Reset clears the sequencer and the output valid only; the tables and stores
//   keep no reset value and must be written before use. No clearing pass runs.
module hub_label_distance_query_core #(
   parameter int unsigned VERTEX_COUNT = hldq_pkg::VERTEX_COUNT_DEF,
   parameter int unsigned LABEL_DEPTH  = hldq_pkg::LABEL_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // write_index, write_hub, write_value, source_vertex, target_vertex, zero pad
   input  logic [hldq_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_type
   input  logic [hldq_pkg::KIND_W-1:0]     req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // smallest summed distance, zero pad
   output logic [hldq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // found
   output logic                            rsp_tuser
);

   hldq_pkg::ctrl_cmd_type cmd;
   hldq_pkg::dp_stat_type  stat;

   // sequencer
   hldq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // tables, stores and merge datapath
   hldq_dp #(
      .VERTEX_COUNT (VERTEX_COUNT),
      .LABEL_DEPTH  (LABEL_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[sv/hldq_ctrl.sv]
// Sequencer of the hub-label distance query core.
`timescale 1ns / 1ps

module hldq_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   input  logic [hldq_pkg::KIND_W-1:0]  req_tuser,
   output logic                         req_tready,
   input  hldq_pkg::dp_stat_type        stat,
   output hldq_pkg::ctrl_cmd_type       cmd
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_OFF_LO = 6'b000010,
      ST_OFF_HI = 6'b000100,
      ST_BOUNDS = 6'b001000,
      ST_MERGE  = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;
   hldq_pkg::req_kind_type req_kind;

   assign req_kind   = hldq_pkg::req_kind_type'(req_tuser);
   assign req_tready = (state_ff == ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (req_kind == hldq_pkg::REQ_QUERY) begin
                  cmd.q_start = 1'b1;
                  state_in    = ST_OFF_LO;
               end
            end
         end
         ST_OFF_LO: begin
            state_in = ST_OFF_HI;
         end
         ST_OFF_HI: begin
            cmd.off_hi   = 1'b1;
            cmd.lo_latch = 1'b1;
            state_in     = ST_BOUNDS;
         end
         ST_BOUNDS: begin
            cmd.bounds = 1'b1;
            state_in   = ST_MERGE;
         end
         ST_MERGE: begin
            if (stat.active) begin
               cmd.step = 1'b1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[sv/hldq_dp.sv]
// Datapath of the hub-label distance query core: tables, label stores, merge, result register.
`timescale 1ns / 1ps
`include "hub_label_distance_query_core_assert.svh"

module hldq_dp #(
   parameter int unsigned VERTEX_COUNT = hldq_pkg::VERTEX_COUNT_DEF,
   parameter int unsigned LABEL_DEPTH  = hldq_pkg::LABEL_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  hldq_pkg::ctrl_cmd_type            cmd,
   output hldq_pkg::dp_stat_type             stat,
   input  logic [hldq_pkg::KIND_W-1:0]       req_tuser,
   input  logic [hldq_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [hldq_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tuser
);

   localparam int unsigned OFF_DEPTH = VERTEX_COUNT + 1;
   localparam int unsigned OFF_AW    = $clog2(OFF_DEPTH);
   localparam int unsigned OFS_W     = $clog2(LABEL_DEPTH + 1);
   localparam int unsigned ST_AW     = $clog2(LABEL_DEPTH);

   // request fields
   logic [hldq_pkg::IDX_W-1:0]  wr_index;
   logic [hldq_pkg::HUB_W-1:0]  wr_hub;
   logic [hldq_pkg::DIST_W-1:0] wr_value;
   logic [hldq_pkg::VTX_W-1:0]  src_vtx;
   logic [hldq_pkg::VTX_W-1:0]  dst_vtx;
   hldq_pkg::req_kind_type      wr_kind;

   assign wr_index = req_tdata[hldq_pkg::IDX_LSB +: hldq_pkg::IDX_W];
   assign wr_hub   = req_tdata[hldq_pkg::HUB_LSB +: hldq_pkg::HUB_W];
   assign wr_value = req_tdata[hldq_pkg::VAL_LSB +: hldq_pkg::DIST_W];
   assign src_vtx  = req_tdata[hldq_pkg::SRC_LSB +: hldq_pkg::VTX_W];
   assign dst_vtx  = req_tdata[hldq_pkg::DST_LSB +: hldq_pkg::VTX_W];
   assign wr_kind  = hldq_pkg::req_kind_type'(req_tuser);

   // memories
   logic [OFS_W-1:0]    fwd_off_mem [OFF_DEPTH];
   logic [OFS_W-1:0]    bwd_off_mem [OFF_DEPTH];
   hldq_pkg::label_type fwd_st_mem  [LABEL_DEPTH];
   hldq_pkg::label_type bwd_st_mem  [LABEL_DEPTH];

   // write decode
   logic                off_wr_ok;
   logic                st_wr_ok;
   logic [OFF_AW-1:0]   off_waddr;
   logic [ST_AW-1:0]    st_waddr;
   logic [OFS_W-1:0]    ofs_val;
   hldq_pkg::label_type st_wdata;
   logic                fwd_off_we;
   logic                bwd_off_we;
   logic                fwd_st_we;
   logic                bwd_st_we;

   assign off_wr_ok  = 32'(wr_index) <= 32'(VERTEX_COUNT);
   assign st_wr_ok   = 32'(wr_index) < 32'(LABEL_DEPTH);
   assign off_waddr  = OFF_AW'(32'(wr_index));
   assign st_waddr   = ST_AW'(32'(wr_index));
   assign ofs_val    = (32'(wr_value) > 32'(LABEL_DEPTH)) ? OFS_W'(LABEL_DEPTH)
                                                          : OFS_W'(wr_value);
   assign st_wdata   = '{hub: wr_hub, cost: wr_value};
   assign fwd_off_we = cmd.accept && (wr_kind == hldq_pkg::REQ_FWD_OFS) && off_wr_ok;
   assign bwd_off_we = cmd.accept && (wr_kind == hldq_pkg::REQ_BWD_OFS) && off_wr_ok;
   assign fwd_st_we  = cmd.accept && (wr_kind == hldq_pkg::REQ_FWD_LBL) && st_wr_ok;
   assign bwd_st_we  = cmd.accept && (wr_kind == hldq_pkg::REQ_BWD_LBL) && st_wr_ok;

   // query vertices
   logic [OFF_AW-1:0] src_ff;
   logic [OFF_AW-1:0] dst_ff;
   logic              src_bad_ff;
   logic              dst_bad_ff;

   always_ff @(posedge clock) begin
      if (cmd.q_start) begin
         src_ff     <= OFF_AW'(32'(src_vtx));
         dst_ff     <= OFF_AW'(32'(dst_vtx));
         src_bad_ff <= 32'(src_vtx) >= 32'(VERTEX_COUNT);
         dst_bad_ff <= 32'(dst_vtx) >= 32'(VERTEX_COUNT);
      end
   end

   // offset table read address: entry v, then v+1
   logic [OFF_AW-1:0] off_raddr_f;
   logic [OFF_AW-1:0] off_raddr_b;
   logic [OFS_W-1:0]  fwd_off_rd_ff;
   logic [OFS_W-1:0]  bwd_off_rd_ff;

   assign off_raddr_f = cmd.off_hi ? src_ff + OFF_AW'(1) : src_ff;
   assign off_raddr_b = cmd.off_hi ? dst_ff + OFF_AW'(1) : dst_ff;

   // offset tables
   always_ff @(posedge clock) begin
      if (fwd_off_we) begin
         fwd_off_mem[off_waddr] <= ofs_val;
      end
      fwd_off_rd_ff <= fwd_off_mem[off_raddr_f];
   end

   always_ff @(posedge clock) begin
      if (bwd_off_we) begin
         bwd_off_mem[off_waddr] <= ofs_val;
      end
      bwd_off_rd_ff <= bwd_off_mem[off_raddr_b];
   end

   // start offsets
   logic [OFS_W-1:0] f_lo_ff;
   logic [OFS_W-1:0] b_lo_ff;

   always_ff @(posedge clock) begin
      if (cmd.lo_latch) begin
         f_lo_ff <= fwd_off_rd_ff;
         b_lo_ff <= bwd_off_rd_ff;
      end
   end

   // list bounds: empty for an out-of-range vertex, end never below start
   logic [OFS_W-1:0] f_lo_c;
   logic [OFS_W-1:0] f_hi_c;
   logic [OFS_W-1:0] b_lo_c;
   logic [OFS_W-1:0] b_hi_c;

   always_comb begin
      f_lo_c = src_bad_ff ? '0 : f_lo_ff;
      f_hi_c = src_bad_ff ? '0 : ((fwd_off_rd_ff < f_lo_ff) ? f_lo_ff : fwd_off_rd_ff);
      b_lo_c = dst_bad_ff ? '0 : b_lo_ff;
      b_hi_c = dst_bad_ff ? '0 : ((bwd_off_rd_ff < b_lo_ff) ? b_lo_ff : bwd_off_rd_ff);
   end

   // merge cursors
   logic [OFS_W-1:0]    si_ff;
   logic [OFS_W-1:0]    si_in;
   logic [OFS_W-1:0]    se_ff;
   logic [OFS_W-1:0]    ti_ff;
   logic [OFS_W-1:0]    ti_in;
   logic [OFS_W-1:0]    te_ff;
   hldq_pkg::label_type fwd_st_rd_ff;
   hldq_pkg::label_type bwd_st_rd_ff;
   logic                hub_eq;
   logic                hub_lt;
   logic                adv_f;
   logic                adv_b;

   assign hub_eq = fwd_st_rd_ff.hub == bwd_st_rd_ff.hub;
   assign hub_lt = fwd_st_rd_ff.hub <  bwd_st_rd_ff.hub;
   assign adv_f  = hub_eq || hub_lt;
   assign adv_b  = !hub_lt;

   // next cursor also addresses the label stores, so data meets the cursor
   always_comb begin
      si_in = si_ff;
      ti_in = ti_ff;
      if (cmd.bounds) begin
         si_in = f_lo_c;
         ti_in = b_lo_c;
      end else if (cmd.step) begin
         si_in = si_ff + OFS_W'(adv_f);
         ti_in = ti_ff + OFS_W'(adv_b);
      end
   end

   always_ff @(posedge clock) begin
      si_ff <= si_in;
      ti_ff <= ti_in;
      if (cmd.bounds) begin
         se_ff <= f_hi_c;
         te_ff <= b_hi_c;
      end
   end

   // label stores
   always_ff @(posedge clock) begin
      if (fwd_st_we) begin
         fwd_st_mem[st_waddr] <= st_wdata;
      end
      fwd_st_rd_ff <= fwd_st_mem[si_in[ST_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (bwd_st_we) begin
         bwd_st_mem[st_waddr] <= st_wdata;
      end
      bwd_st_rd_ff <= bwd_st_mem[ti_in[ST_AW-1:0]];
   end

   // saturated sum and running minimum
   logic [hldq_pkg::DIST_W:0]   sum_c;
   logic [hldq_pkg::DIST_W-1:0] sat_c;
   logic [hldq_pkg::DIST_W-1:0] best_ff;
   logic                        hit_ff;

   assign sum_c = {1'b0, fwd_st_rd_ff.cost} + {1'b0, bwd_st_rd_ff.cost};
   assign sat_c = sum_c[hldq_pkg::DIST_W] ? hldq_pkg::DIST_MAX
                                          : sum_c[hldq_pkg::DIST_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.bounds) begin
         best_ff <= hldq_pkg::DIST_MAX;
         hit_ff  <= 1'b0;
      end else if (cmd.step && hub_eq) begin
         hit_ff <= 1'b1;
         if (sat_c < best_ff) begin
            best_ff <= sat_c;
         end
      end
   end

   // output register
   logic                        rsp_valid_ff;
   logic [hldq_pkg::DIST_W-1:0] rsp_dist_ff;
   logic                        rsp_found_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_dist_ff  <= hit_ff ? best_ff : '0;
         rsp_found_ff <= hit_ff;
      end
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_tdata     = hldq_pkg::RSP_DATA_W'(rsp_dist_ff);
   assign rsp_tuser     = rsp_found_ff;
   assign stat.active   = (si_ff < se_ff) && (ti_ff < te_ff);
   assign stat.rsp_free = !rsp_valid_ff || rsp_tready;

   // checks
   `HLDQ_ASSERT_NXT(a_cursor_in_range, clock, reset, cmd.step,
                    (si_ff <= se_ff) && (ti_ff <= te_ff))
   `HLDQ_ASSERT_NXT(a_step_advances, clock, reset, cmd.step,
                    (si_ff != $past(si_ff)) || (ti_ff != $past(ti_ff)))
   `HLDQ_ASSERT_IMP(a_load_when_free, clock, reset, cmd.load_rsp,
                    !rsp_valid_ff || rsp_tready)
   `HLDQ_ASSERT_IMP(a_miss_is_zero, clock, reset, rsp_valid_ff && !rsp_found_ff,
                    rsp_dist_ff == '0)

endmodule

[tb/hub_label_distance_query_core_test.sv]
// Self-checking testbench for the hub-label distance query core.
`timescale 1ns / 1ps

module hub_label_distance_query_core_test;

   localparam int unsigned VC = hldq_pkg::VERTEX_COUNT_DEF;
   localparam int unsigned LD = hldq_pkg::LABEL_DEPTH_DEF;
   localparam int unsigned KW = hldq_pkg::KIND_W;
   localparam int unsigned IW = hldq_pkg::IDX_W;
   localparam int unsigned HW = hldq_pkg::HUB_W;
   localparam int unsigned DW = hldq_pkg::DIST_W;
   localparam int unsigned VW = hldq_pkg::VTX_W;
   localparam int unsigned RW = hldq_pkg::REQ_DATA_W;
   localparam int unsigned SW = hldq_pkg::RSP_DATA_W;
   localparam int KIND_LAST = (1 << KW) - 1;
   localparam int IDLE_PCT = 21;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 60;
   localparam int REPORT_LIMIT = 10;

   // expected answer of one query
   typedef struct packed {
      logic [DW-1:0] min_dist;
      logic          found;
   } hop_answer_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [RW-1:0] req_tdata = '0;
   logic [KW-1:0] req_tuser = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [SW-1:0] rsp_tdata;
   logic          rsp_tuser;

   // mirror of the block's tables and stores
   logic [12:0]         fwd_offsets [0:VC];
   logic [12:0]         bwd_offsets [0:VC];
   hldq_pkg::label_type fwd_labels [0:LD-1];
   hldq_pkg::label_type bwd_labels [0:LD-1];
   bit                  fwd_offset_set [0:VC];
   bit                  bwd_offset_set [0:VC];
   bit                  fwd_label_set [0:LD-1];
   bit                  bwd_label_set [0:LD-1];

   hop_answer_type pending_answers [$];

   int  fail_count = 0;
   int  beats_sent = 0;
   int  queries_sent = 0;
   int  hits_predicted = 0;
   int  answers_checked = 0;
   int  idle_cycles = 0;
   bit  calm = 1'b0;
   bit  hold_off_request = 1'b0;

   hub_label_distance_query_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // list bounds of one vertex, clamped and never inverted
   function automatic void list_span(input bit backward, input int unsigned v,
                                     output int unsigned lo, output int unsigned hi);
      int unsigned a;
      int unsigned b;
      if (v >= VC) begin
         lo = 0;
         hi = 0;
         return;
      end
      a = 32'(backward ? bwd_offsets[v] : fwd_offsets[v]);
      b = 32'(backward ? bwd_offsets[v + 1] : fwd_offsets[v + 1]);
      if (a > LD) a = LD;
      if (b > LD) b = LD;
      if (b < a) b = a;
      lo = a;
      hi = b;
   endfunction

   // a query may only touch entries that were written
   function automatic bit query_readable(input int unsigned src, input int unsigned dst);
      int unsigned lo;
      int unsigned hi;
      int unsigned i;
      if (src < VC) begin
         if (!fwd_offset_set[src] || !fwd_offset_set[src + 1]) return 1'b0;
         list_span(1'b0, src, lo, hi);
         for (i = lo; i < hi; i++)
            if (!fwd_label_set[i]) return 1'b0;
      end
      if (dst < VC) begin
         if (!bwd_offset_set[dst] || !bwd_offset_set[dst + 1]) return 1'b0;
         list_span(1'b1, dst, lo, hi);
         for (i = lo; i < hi; i++)
            if (!bwd_label_set[i]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // merge-join forward list of src with backward list of dst
   function automatic hop_answer_type join_lists(input int unsigned src,
                                                 input int unsigned dst);
      int unsigned si;
      int unsigned se;
      int unsigned ti;
      int unsigned te;
      logic [DW:0]   sum;
      logic [DW-1:0] s;
      logic [DW-1:0] best;
      bit                  hit;
      hldq_pkg::label_type a;
      hldq_pkg::label_type b;
      hop_answer_type      ans;
      best = hldq_pkg::DIST_MAX;
      hit = 1'b0;
      list_span(1'b0, src, si, se);
      list_span(1'b1, dst, ti, te);
      while (si < se && ti < te) begin
         a = fwd_labels[si];
         b = bwd_labels[ti];
         if (a.hub == b.hub) begin
            sum = {1'b0, a.cost} + {1'b0, b.cost};
            s = (sum > {1'b0, hldq_pkg::DIST_MAX}) ? hldq_pkg::DIST_MAX : sum[DW-1:0];
            if (!hit || s < best) best = s;
            hit = 1'b1;
            si++;
            ti++;
         end else if (a.hub < b.hub) begin
            si++;
         end else begin
            ti++;
         end
      end
      ans.min_dist = hit ? best : '0;
      ans.found = hit;
      return ans;
   endfunction

   // update the mirror for one accepted beat
   function automatic void apply_request(input logic [KW-1:0] kind,
                                         input logic [IW-1:0] idx,
                                         input logic [HW-1:0] hub,
                                         input logic [DW-1:0] val,
                                         input logic [VW-1:0] src,
                                         input logic [VW-1:0] dst);
      logic [12:0]    ofs;
      hop_answer_type ans;
      ofs = (val > LD) ? LD[12:0] : val[12:0];
      case (kind)
         hldq_pkg::REQ_FWD_OFS: begin
            if (idx <= VC) begin
               fwd_offsets[idx] = ofs;
               fwd_offset_set[idx] = 1'b1;
            end
         end
         hldq_pkg::REQ_BWD_OFS: begin
            if (idx <= VC) begin
               bwd_offsets[idx] = ofs;
               bwd_offset_set[idx] = 1'b1;
            end
         end
         hldq_pkg::REQ_FWD_LBL: begin
            if (idx < LD) begin
               fwd_labels[idx] = '{hub: hub, cost: val};
               fwd_label_set[idx] = 1'b1;
            end
         end
         hldq_pkg::REQ_BWD_LBL: begin
            if (idx < LD) begin
               bwd_labels[idx] = '{hub: hub, cost: val};
               bwd_label_set[idx] = 1'b1;
            end
         end
         hldq_pkg::REQ_QUERY: begin
            ans = join_lists(32'(src), 32'(dst));
            pending_answers = {pending_answers, ans};
            queries_sent++;
            if (ans.found) hits_predicted++;
         end
         default: ;
      endcase
   endfunction

   // present one beat, with random idle cycles ahead of it
   task automatic send_request(input logic [KW-1:0] kind,
                               input logic [IW-1:0] idx,
                               input logic [HW-1:0] hub,
                               input logic [DW-1:0] val,
                               input logic [VW-1:0] src,
                               input logic [VW-1:0] dst);
      logic [RW-1:0] d;
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      d = '0;
      d[hldq_pkg::IDX_LSB +: IW] = idx;
      d[hldq_pkg::HUB_LSB +: HW] = hub;
      d[hldq_pkg::VAL_LSB +: DW] = val;
      d[hldq_pkg::SRC_LSB +: VW] = src;
      d[hldq_pkg::DST_LSB +: VW] = dst;
      req_tvalid <= 1'b1;
      req_tdata <= d;
      req_tuser <= kind;
      do @(posedge clock); while (!req_tready);
      beats_sent++;
      apply_request(kind, idx, hub, val, src, dst);
   endtask

   // write beats fill the unused fields with noise
   task automatic write_offset(input logic [KW-1:0] kind, input int unsigned idx,
                               input int unsigned val);
      send_request(kind, idx[IW-1:0], HW'($urandom), val[DW-1:0], VW'($urandom),
                   VW'($urandom));
   endtask

   task automatic write_label(input logic [KW-1:0] kind, input int unsigned idx,
                              input int unsigned hub, input int unsigned cost);
      send_request(kind, idx[IW-1:0], hub[HW-1:0], cost[DW-1:0],
                   VW'($urandom), VW'($urandom));
   endtask

   task automatic run_query(input int unsigned src, input int unsigned dst);
      if (!query_readable(src, dst)) return;
      send_request(hldq_pkg::REQ_QUERY, IW'($urandom), HW'($urandom), DW'($urandom),
                   src[VW-1:0], dst[VW-1:0]);
   endtask

   // occasional beats that the block must ignore
   task automatic maybe_noise();
      int r;
      r = $urandom_range(0, 29);
      if (r == 0)
         send_request(KW'($urandom_range(int'(hldq_pkg::REQ_QUERY) + 1, KIND_LAST)),
                      IW'($urandom), HW'($urandom), DW'($urandom), VW'($urandom),
                      VW'($urandom));
      else if (r == 1)
         write_offset($urandom_range(0, 1) ? hldq_pkg::REQ_BWD_OFS : hldq_pkg::REQ_FWD_OFS,
                      $urandom_range(VC + 1, (1 << IW) - 1), $urandom);
   endtask

   // lay out the lists of a run of vertices in one direction
   task automatic lay_out_lists(input bit backward, output int v_first, output int v_count);
      int total;
      int a0;
      int pos;
      int i;
      int j;
      int h;
      int r;
      int unsigned cost;
      int unsigned ofs_val;
      bit dense;
      bit unsorted;
      int lens [0:8];
      logic [KW-1:0] ofs_kind;
      logic [KW-1:0] lbl_kind;
      ofs_kind = backward ? hldq_pkg::REQ_BWD_OFS : hldq_pkg::REQ_FWD_OFS;
      lbl_kind = backward ? hldq_pkg::REQ_BWD_LBL : hldq_pkg::REQ_FWD_LBL;
      v_count = $urandom_range(2, 8);
      v_first = ($urandom_range(0, 5) == 0) ? VC - v_count : $urandom_range(0, VC - v_count);
      total = 0;
      for (i = 0; i < v_count; i++) begin
         lens[i] = $urandom_range(0, 6);
         total += lens[i];
      end
      // sometimes the region ends right at the top of the store
      a0 = ($urandom_range(0, 3) == 0) ? LD - total : $urandom_range(0, LD - total);

      // offset table: running start addresses
      pos = a0;
      for (i = 0; i <= v_count; i++) begin
         ofs_val = pos;
         if (pos == LD) ofs_val = $urandom_range(LD, hldq_pkg::DIST_MAX);
         write_offset(ofs_kind, v_first + i, ofs_val);
         maybe_noise();
         if (i < v_count) pos += lens[i];
      end
      // pull one boundary back so a list ends below its start
      if ($urandom_range(0, 7) == 0) begin
         j = $urandom_range(1, v_count - 1);
         write_offset(ofs_kind, v_first + j, a0);
      end

      // label entries, mostly ascending by hub
      dense = $urandom_range(0, 1);
      pos = a0;
      for (i = 0; i < v_count; i++) begin
         h = dense ? $urandom_range(0, 8) : $urandom_range(0, 600);
         unsorted = ($urandom_range(0, 9) == 0);
         for (j = 0; j < lens[i]; j++) begin
            r = $urandom_range(0, 9);
            if (r < 5) cost = $urandom_range(0, 200);
            else if (r < 8) cost = $urandom & hldq_pkg::DIST_MAX;
            else cost = hldq_pkg::DIST_MAX - $urandom_range(0, 50);
            write_label(lbl_kind, pos, h, cost);
            pos++;
            maybe_noise();
            if (unsorted) h = $urandom_range(0, (1 << HW) - 1);
            else h += dense ? $urandom_range(0, 3) : $urandom_range(1, 300);
            if (h > (1 << HW) - 1) h = (1 << HW) - 1;
         end
      end
   endtask

   // one small graph and a batch of queries over it
   task automatic build_graph_phase();
      int fv;
      int fc;
      int bv;
      int bc;
      int q;
      int n;
      lay_out_lists(1'b0, fv, fc);
      lay_out_lists(1'b1, bv, bc);
      n = $urandom_range(20, 36);
      for (q = 0; q < n; q++) begin
         if ($urandom_range(0, 9) == 0)
            run_query($urandom_range(0, VC - 1), $urandom_range(0, VC - 1));
         else
            run_query(fv + $urandom_range(0, fc - 1), bv + $urandom_range(0, bc - 1));
         maybe_noise();
      end
   endtask

   // store extremes, saturation, empty and disjoint lists, ignored beats
   task automatic test_directed_cases();
      int k;
      write_offset(hldq_pkg::REQ_FWD_OFS, 0, LD - 2);
      write_offset(hldq_pkg::REQ_FWD_OFS, 1, hldq_pkg::DIST_MAX);
      write_label(hldq_pkg::REQ_FWD_LBL, LD - 2, 5, hldq_pkg::DIST_MAX - 15);
      write_label(hldq_pkg::REQ_FWD_LBL, LD - 1, (1 << HW) - 1, 10);
      write_offset(hldq_pkg::REQ_BWD_OFS, VC - 1, 0);
      write_offset(hldq_pkg::REQ_BWD_OFS, VC, 2);
      write_label(hldq_pkg::REQ_BWD_LBL, 0, 5, 256);
      write_label(hldq_pkg::REQ_BWD_LBL, 1, (1 << HW) - 1, 7);
      // one sum saturates, the other is the minimum
      run_query(0, VC - 1);
      // every sum saturates, still found
      write_label(hldq_pkg::REQ_BWD_LBL, 1, (1 << HW) - 1, hldq_pkg::DIST_MAX);
      run_query(0, VC - 1);
      // unknown kinds and writes past the offset table
      for (k = int'(hldq_pkg::REQ_QUERY) + 1; k <= KIND_LAST; k++)
         send_request(k[KW-1:0], IW'($urandom), HW'($urandom), DW'($urandom),
                      VW'($urandom), VW'($urandom));
      write_offset(hldq_pkg::REQ_BWD_OFS, (1 << IW) - 1, 0);
      write_offset(hldq_pkg::REQ_FWD_OFS, VC + 1, 0);
      // end offset below start gives an empty list
      write_offset(hldq_pkg::REQ_BWD_OFS, VC - 1, 3);
      run_query(0, VC - 1);
      // lists with no hub in common
      write_offset(hldq_pkg::REQ_BWD_OFS, VC - 1, 0);
      write_label(hldq_pkg::REQ_BWD_LBL, 0, 4, 0);
      write_label(hldq_pkg::REQ_BWD_LBL, 1, (1 << HW) - 2, 0);
      run_query(0, VC - 1);
   endtask

   task automatic test_random_graphs(input int target);
      int phase;
      phase = 0;
      while (beats_sent < target) begin
         calm = (phase >= 3 && phase < 6);
         build_graph_phase();
         phase++;
      end
      calm = 1'b0;
   endtask

   // receiver holds off while the sender keeps offering beats
   task automatic test_input_stall();
      hold_off_request = 1'b1;
      build_graph_phase();
   endtask

   // receiver: random idling, or a long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // compare each response beat with the oldest expected answer
   always @(posedge clock) begin : answer_check
      hop_answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         answers_checked++;
         if (pending_answers.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("unexpected response: data=%h found=%b", rsp_tdata, rsp_tuser);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_tdata !== {{(SW - DW){1'b0}}, want.min_dist} ||
                rsp_tuser !== want.found) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("response mismatch: expected dist=%0d found=%b, got data=%h found=%b",
                           want.min_dist, want.found, rsp_tdata, rsp_tuser);
            end
         end
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d answers outstanding",
                     idle_cycles, pending_answers.size());
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_random_graphs(700);
      test_input_stall();
      test_random_graphs(1350);

      req_tvalid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d request beats including %0d queries (%0d with a shared hub);",
               beats_sent, queries_sent, hits_predicted);
      $display("checked %0d responses, %0d failures.", answers_checked, fail_count);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
